[rtl/gf2m_pbm_pkg.sv]
`timescale 1ns / 1ps

package gf2m_pbm_pkg;

    // Coordinate word width and digit size of the cell row
    localparam int WORD_BITS   = 64;
    localparam int DIGIT_BITS  = 8;
    localparam int STEPS       = WORD_BITS / DIGIT_BITS;
    localparam int CNT_BITS    = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int FIELD_BITS  = 64;
    localparam int PROD_BITS   = 63;

    localparam logic [FIELD_BITS-1:0] RESET_POLY = FIELD_BITS'(19);

    // Row control from the sequencer
    typedef struct packed {
        logic load;   // take new operands, start the operand reduction
        logic step;   // run one digit through the cells
        logic swap;   // last reduction digit: keep reduced operand, start multiply
    } t_row_ctrl;

    // One-hot mask of bit m-1, where m is the degree of the polynomial.
    // Zero when the polynomial has degree below one.
    function automatic logic [WORD_BITS-1:0] top_mask(input logic [WORD_BITS-1:0] poly);
        logic [WORD_BITS-1:0] s;
        s = poly >> 1;
        for (int k = 1; k < WORD_BITS; k = k * 2) begin
            s = s | (s >> k);
        end
        return s & ~(s >> 1);
    endfunction

endpackage

[rtl/gf2m_pbm_cell.sv]
`timescale 1ns / 1ps

// One MSB-first step: acc = acc * x mod P, then add the addend if the bit is set
module gf2m_pbm_cell (
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0] i_acc,
    input  logic                               i_bit,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0] i_addend,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0] i_poly,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0] i_tmask,
    output logic [gf2m_pbm_pkg::WORD_BITS-1:0] o_acc
);

    logic w_fb;

    // Top coefficient about to reach degree m
    assign w_fb = |(i_acc & i_tmask);

    // Shift, reduce, accumulate
    assign o_acc = {i_acc[gf2m_pbm_pkg::WORD_BITS-2:0], 1'b0}
                 ^ (w_fb  ? i_poly   : '0)
                 ^ (i_bit ? i_addend : '0);

endmodule

[rtl/gf2m_pbm_row.sv]
`timescale 1ns / 1ps

// Row of cells that folds one digit of the multiplier word per cycle.
// First pass reduces operand a (multiplier bits = a, addend = 1),
// second pass multiplies by b (multiplier bits = b, addend = a mod P).
module gf2m_pbm_row (
    input  logic                                 i_clk,
    input  gf2m_pbm_pkg::t_row_ctrl              i_ctrl,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0]   i_operand_a,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0]   i_operand_b,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0]   i_poly,
    input  logic [gf2m_pbm_pkg::WORD_BITS-1:0]   i_tmask,
    output logic [gf2m_pbm_pkg::WORD_BITS-1:0]   o_acc
);

    localparam int W = gf2m_pbm_pkg::WORD_BITS;
    localparam int D = gf2m_pbm_pkg::DIGIT_BITS;

    logic [W-1:0] r_acc;
    logic [W-1:0] r_digits;
    logic [W-1:0] r_addend;
    logic [W-1:0] r_b;
    logic [W-1:0] w_chain [D+1];

    assign w_chain[0] = r_acc;

    // Cells handle the current digit, most significant bit first
    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            gf2m_pbm_cell u_cell (
                .i_acc    (w_chain[g]),
                .i_bit    (r_digits[W-1-g]),
                .i_addend (r_addend),
                .i_poly   (i_poly),
                .i_tmask  (i_tmask),
                .o_acc    (w_chain[g+1])
            );
        end
    endgenerate

    // Load operands, advance one digit, or switch from reduction to multiply
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc    <= '0;
            r_digits <= i_operand_a;
            r_addend <= W'(1);
            r_b      <= i_operand_b;
        end else if (i_ctrl.step) begin
            if (i_ctrl.swap) begin
                r_acc    <= '0;
                r_digits <= r_b;
                r_addend <= w_chain[D];
            end else begin
                r_acc    <= w_chain[D];
                r_digits <= r_digits << D;
            end
        end
    end

    assign o_acc = r_acc;

endmodule

[rtl/gf2m_poly_basis_multiplier_top.sv]
`timescale 1ns / 1ps

// Each item reduces operand a digit by digit, multiplies by b digit by digit, and goes to the
// output register, waiting while an earlier result is untaken. The next item is taken
// only after the result is loaded; the 8-bit-per-cycle cell row is shared by both passes.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the sequencer and output valid and loads
// the field polynomial x^4 + x + 1.
module gf2m_poly_basis_multiplier_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [63:0]                           i_operand_a,
    input  logic [63:0]                           i_operand_b,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [gf2m_pbm_pkg::PROD_BITS-1:0]    o_product,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gf2m_pbm_pkg::FIELD_BITS-1:0]   i_cfg_field_polynomial
);

    localparam int W  = gf2m_pbm_pkg::WORD_BITS;
    localparam int CB = gf2m_pbm_pkg::CNT_BITS;
    localparam logic [CB-1:0] LAST = CB'(gf2m_pbm_pkg::STEPS - 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_MULT   = 4'b0100,
        S_WAIT   = 4'b1000
    } t_state;

    t_state                                r_state, n_state;
    logic [CB-1:0]                         r_cnt, n_cnt;
    logic [gf2m_pbm_pkg::FIELD_BITS-1:0]   r_poly;
    logic [W-1:0]                          r_tmask;
    logic                                  r_out_valid, n_out_valid;
    logic [gf2m_pbm_pkg::PROD_BITS-1:0]    r_prod;
    gf2m_pbm_pkg::t_row_ctrl               w_ctrl;
    logic [W-1:0]                          w_acc;
    logic                                  w_in_xfer;
    logic                                  w_out_load;
    logic                                  w_last;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_product   = r_prod;

    assign w_in_xfer  = i_in_valid & o_in_ready;
    assign w_last     = (r_cnt == LAST);
    assign w_out_load = (r_state == S_WAIT) & (~r_out_valid | i_out_ready);

    // Drive the cell row
    always_comb begin
        w_ctrl.load = w_in_xfer;
        w_ctrl.step = (r_state == S_REDUCE) | (r_state == S_MULT);
        w_ctrl.swap = (r_state == S_REDUCE) & w_last;
    end

    gf2m_pbm_row u_row (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .i_operand_a (i_operand_a[W-1:0]),
        .i_operand_b (i_operand_b[W-1:0]),
        .i_poly      (r_poly[W-1:0]),
        .i_tmask     (r_tmask),
        .o_acc       (w_acc)
    );

    // Sequence: reduce a, multiply by b, hand result to the output register
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_REDUCE;
                    n_cnt   = '0;
                end
            end
            S_REDUCE: begin
                n_cnt = w_last ? '0 : r_cnt + CB'(1);
                if (w_last) begin
                    n_state = S_MULT;
                end
            end
            S_MULT: begin
                n_cnt = w_last ? '0 : r_cnt + CB'(1);
                if (w_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // Output valid: set on load, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_poly      <= gf2m_pbm_pkg::RESET_POLY;
            r_tmask     <= gf2m_pbm_pkg::top_mask(gf2m_pbm_pkg::RESET_POLY[W-1:0]);
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            // Take a new field polynomial and precompute its top-bit mask
            if (i_cfg_valid) begin
                r_poly  <= i_cfg_field_polynomial;
                r_tmask <= gf2m_pbm_pkg::top_mask(i_cfg_field_polynomial[W-1:0]);
            end
        end
    end

    // Result register; a polynomial of degree below one gives zero
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_prod <= (r_tmask == '0) ? '0 : gf2m_pbm_pkg::PROD_BITS'(w_acc);
        end
    end

`ifndef SYNTH
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == S_REDUCE) && (r_cnt == '0))
        else $error("reduction pass did not start after input transfer");

    a_reduce_to_mult: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REDUCE) && w_last |=> (r_state == S_MULT) && (r_cnt == '0))
        else $error("multiply pass did not follow reduction pass");

    a_mult_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULT) && w_last |=> (r_state == S_WAIT))
        else $error("multiply pass did not finish");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) && r_out_valid && !i_out_ready
        |=> (r_state == S_WAIT) && $stable(r_prod))
        else $error("pending result overwritten");

    a_tmask_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(r_tmask))
        else $error("top-bit mask has more than one bit set");
`endif

endmodule
